/* hw/rtl/mtl_pkg.sv */
// Shared types, codes and helpers of the multiview tile layout block.
package mtl_pkg;

    localparam int MAX_TILES  = 256;
    localparam int TOTAL_W    = 9;
    localparam int CELL_W     = 8;
    localparam int SLOT_W     = 5;
    localparam int MODE_W     = 3;
    localparam int DIV_STEPS  = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_GRID        = 3'd0,
        MODE_HEADERS     = 3'd1,
        MODE_CORNERS     = 3'd2,
        MODE_TOP_LEFT    = 3'd3,
        MODE_CENTER      = 3'd4,
        MODE_QUAD_CENTER = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        REG_GRID_MODE    = 3'd0,
        REG_RING_SLOTS   = 3'd1,
        REG_ACROSS_SLOTS = 3'd2,
        REG_DOWN_SLOTS   = 3'd3,
        REG_ACROSS_CELLS = 3'd4,
        REG_DOWN_CELLS   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [MODE_W-1:0] grid_mode;
        logic [SLOT_W-1:0] ring_slots;
        logic [SLOT_W-1:0] across_slots;
        logic [SLOT_W-1:0] down_slots;
        logic [CELL_W-1:0] across_cells;
        logic [CELL_W-1:0] down_cells;
    } cfg_t;

    // One lane of the restoring divider: remainder, dividend/quotient, divisor.
    typedef struct packed {
        logic [SLOT_W-1:0] rem;
        logic [CELL_W-1:0] quo;
        logic [SLOT_W-1:0] dsr;
    } div_lane_t;

    // Beat traveling through the pipeline. Lane 0: width, 1: height, 2: index.
    typedef struct packed {
        logic [CELL_W-1:0]  idx;
        logic               hit;
        logic [TOTAL_W-1:0] total;
        div_lane_t [2:0]    lane;
    } pipe_t;

    typedef struct packed {
        logic               hit;
        logic [TOTAL_W-1:0] total;
        logic [CELL_W-1:0]  col;
        logic [CELL_W-1:0]  row;
        logic [CELL_W-1:0]  w;
        logic [CELL_W-1:0]  h;
    } res_t;

    // Product truncated to cell width.
    function automatic logic [CELL_W-1:0] mul8(input logic [CELL_W-1:0] a,
                                               input logic [CELL_W-1:0] b);
        logic [2*CELL_W-1:0] p;
        begin
            p = a * b;
            return p[CELL_W-1:0];
        end
    endfunction

endpackage

/* hw/rtl/multiview_tile_layout_top.sv */
// Top level of the multiview tile layout block: config, handshake, pipeline.
//
// Use: write the six layout registers through cfg_we/cfg_index/cfg_data while
// no beat is in flight, then send tile indexes on the input channel
// (in_valid/in_stall). Each index returns one beat on the output channel
// (out_valid/out_stall): valid flag, tile count of the mode and the tile's
// start column, start row, width and height in cells.
// Pipeline: four register stages (setup, two divider stages of 4 restoring
// steps each, placement into the output register); out_valid is the valid
// flag of the output register.
// Throughput: one index per cycle while out_stall is low; the 8-step divider
// is split over two stages so every stage can take a new beat each cycle.
// Stall: each stage holds its beat while the stage after it is full and held;
// bubbles close up, and in_stall rises only when all four stages are full
// and out_stall is high. Nothing is dropped or repeated.
// Reset: all stages empty; registers return to grid mode, 2 by 2 slots,
// ring 2, 60 by 60 cells.
module multiview_tile_layout_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [7:0]                   cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [mtl_pkg::CELL_W-1:0]   tile_index,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         tile_valid,
    output logic [mtl_pkg::TOTAL_W-1:0]  tile_total,
    output logic [mtl_pkg::CELL_W-1:0]   start_col,
    output logic [mtl_pkg::CELL_W-1:0]   start_row,
    output logic [mtl_pkg::CELL_W-1:0]   span_cols,
    output logic [mtl_pkg::CELL_W-1:0]   span_rows
);

    mtl_pkg::cfg_t  cfg_reg;
    mtl_pkg::pipe_t s1_beat, s2_beat, s3_beat;
    mtl_pkg::res_t  res;
    logic           v1_reg, v2_reg, v3_reg, vo_reg;
    logic           rdy1, rdy2, rdy3, rdyo;

    // Write layout registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_mode    <= mtl_pkg::MODE_GRID;
            cfg_reg.ring_slots   <= 5'd2;
            cfg_reg.across_slots <= 5'd2;
            cfg_reg.down_slots   <= 5'd2;
            cfg_reg.across_cells <= 8'd60;
            cfg_reg.down_cells   <= 8'd60;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mtl_pkg::REG_GRID_MODE:    cfg_reg.grid_mode    <= cfg_data[2:0];
                mtl_pkg::REG_RING_SLOTS:   cfg_reg.ring_slots   <= cfg_data[4:0];
                mtl_pkg::REG_ACROSS_SLOTS: cfg_reg.across_slots <= cfg_data[4:0];
                mtl_pkg::REG_DOWN_SLOTS:   cfg_reg.down_slots   <= cfg_data[4:0];
                mtl_pkg::REG_ACROSS_CELLS: cfg_reg.across_cells <= cfg_data;
                mtl_pkg::REG_DOWN_CELLS:   cfg_reg.down_cells   <= cfg_data;
                default:                   cfg_reg.grid_mode    <= cfg_reg.grid_mode;
            endcase
        end
    end

    // Advance a stage when it is empty or the next one moves
    assign rdyo     = !vo_reg || !out_stall;
    assign rdy3     = !v3_reg || rdyo;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdyo) vo_reg <= v3_reg;
        end
    end

    mtl_setup u_setup (
        .clk        (clk),
        .en         (rdy1),
        .cfg        (cfg_reg),
        .tile_index (tile_index),
        .beat_reg   (s1_beat)
    );

    mtl_div_stage u_div_hi (
        .clk      (clk),
        .en       (rdy2),
        .beat     (s1_beat),
        .beat_reg (s2_beat)
    );

    mtl_div_stage u_div_lo (
        .clk      (clk),
        .en       (rdy3),
        .beat     (s2_beat),
        .beat_reg (s3_beat)
    );

    mtl_place u_place (
        .clk     (clk),
        .en      (rdyo),
        .cfg     (cfg_reg),
        .beat    (s3_beat),
        .res_reg (res)
    );

    assign out_valid  = vo_reg;
    assign tile_valid = res.hit;
    assign tile_total = res.total;
    assign start_col  = res.col;
    assign start_row  = res.row;
    assign span_cols  = res.w;
    assign span_rows  = res.h;

`ifndef SYNTHESIS
    a_valid_has_tiles: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tile_valid |-> tile_total != '0)
        else $error("valid tile in a layout with no tiles");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tile_valid |-> start_col == '0 && start_row == '0 &&
                                     span_cols == '0 && span_rows == '0)
        else $error("invalid tile with nonzero rectangle");

    a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> tile_total <= 9'(mtl_pkg::MAX_TILES))
        else $error("tile count above limit");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v1_reg && v2_reg && v3_reg && vo_reg && out_stall)
        else $error("input held while the pipeline has room");
`endif

endmodule

/* hw/rtl/mtl_setup.sv */
// First stage: tile count, index check and divider operand setup.
module mtl_setup (
    input  logic                        clk,
    input  logic                        en,
    input  mtl_pkg::cfg_t               cfg,
    input  logic [mtl_pkg::CELL_W-1:0]  tile_index,
    output mtl_pkg::pipe_t              beat_reg
);

    mtl_pkg::pipe_t          beat_next;
    logic [2*mtl_pkg::SLOT_W-1:0] grid_prod;
    logic [10:0]             total_w;
    logic [10:0]             rs11;

    // Count the tiles of the mode and select divisors
    always_comb
    begin
        rs11      = {6'd0, cfg.ring_slots};
        grid_prod = {5'd0, cfg.across_slots} * {5'd0, cfg.down_slots};
        case (cfg.grid_mode)
            mtl_pkg::MODE_GRID:
                total_w = (cfg.across_slots == '0 || cfg.down_slots == '0) ?
                          11'd0 : {1'b0, grid_prod};
            mtl_pkg::MODE_HEADERS:
                total_w = (cfg.across_slots == '0) ? 11'd0 : (rs11 << 1) + 11'd2;
            mtl_pkg::MODE_CORNERS:
                total_w = 11'd7;
            mtl_pkg::MODE_TOP_LEFT:
                total_w = (rs11 < 11'd3) ? 11'd0 : (rs11 << 1);
            mtl_pkg::MODE_CENTER:
                total_w = (rs11 < 11'd4) ? 11'd0 : (rs11 << 2) - 11'd3;
            mtl_pkg::MODE_QUAD_CENTER:
                total_w = (rs11 < 11'd5) ? 11'd0 : (rs11 << 2);
            default:
                total_w = 11'd0;
        endcase
        if (total_w > 11'(mtl_pkg::MAX_TILES))
            total_w = 11'(mtl_pkg::MAX_TILES);

        beat_next.idx   = tile_index;
        beat_next.total = total_w[mtl_pkg::TOTAL_W-1:0];
        beat_next.hit   = ({3'd0, tile_index} < total_w);

        beat_next.lane[0].rem = '0;
        beat_next.lane[0].quo = cfg.across_cells;
        beat_next.lane[0].dsr = (cfg.grid_mode == mtl_pkg::MODE_GRID ||
                                 cfg.grid_mode == mtl_pkg::MODE_HEADERS) ?
                                cfg.across_slots : cfg.ring_slots;
        beat_next.lane[1].rem = '0;
        beat_next.lane[1].quo = cfg.down_cells;
        beat_next.lane[1].dsr = (cfg.grid_mode == mtl_pkg::MODE_GRID) ?
                                cfg.down_slots : cfg.ring_slots;
        beat_next.lane[2].rem = '0;
        beat_next.lane[2].quo = (cfg.grid_mode == mtl_pkg::MODE_HEADERS &&
                                 tile_index >= 8'd2) ? tile_index - 8'd2 : tile_index;
        beat_next.lane[2].dsr = cfg.across_slots;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            beat_reg <= beat_next;
    end

endmodule

/* hw/rtl/mtl_div_stage.sv */
// Divider stage: DIV_STEPS (4) restoring division steps on every lane.
module mtl_div_stage (
    input  logic           clk,
    input  logic           en,
    input  mtl_pkg::pipe_t beat,
    output mtl_pkg::pipe_t beat_reg
);

    mtl_pkg::pipe_t            beat_next;
    logic [mtl_pkg::SLOT_W:0]  trial;

    // Shift in one dividend bit per step, subtract when it fits
    always_comb
    begin
        trial     = '0;
        beat_next = beat;
        for (int l = 0; l < 3; l++)
        begin
            for (int s = 0; s < mtl_pkg::DIV_STEPS; s++)
            begin
                trial = {beat_next.lane[l].rem, beat_next.lane[l].quo[mtl_pkg::CELL_W-1]};
                if (trial >= {1'b0, beat_next.lane[l].dsr})
                begin
                    trial = trial - {1'b0, beat_next.lane[l].dsr};
                    beat_next.lane[l].quo = {beat_next.lane[l].quo[mtl_pkg::CELL_W-2:0], 1'b1};
                end
                else
                begin
                    beat_next.lane[l].quo = {beat_next.lane[l].quo[mtl_pkg::CELL_W-2:0], 1'b0};
                end
                beat_next.lane[l].rem = trial[mtl_pkg::SLOT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            beat_reg <= beat_next;
    end

endmodule

/* hw/rtl/mtl_place.sv */
// Last stage: place the tile rectangle from the quotients.
module mtl_place (
    input  logic           clk,
    input  logic           en,
    input  mtl_pkg::cfg_t  cfg,
    input  mtl_pkg::pipe_t beat,
    output mtl_pkg::res_t  res_reg
);

    mtl_pkg::res_t     res_next;
    logic [7:0]        ac, dc, sw, sh, lw, lh, idx, k, bot, rgt, q2, r2;
    logic [8:0]        k9, rs9;

    // Work out the rectangle per mode
    always_comb
    begin
        ac  = cfg.across_cells;
        dc  = cfg.down_cells;
        idx = beat.idx;
        sw  = beat.lane[0].quo;
        sh  = beat.lane[1].quo;
        q2  = beat.lane[2].quo;
        r2  = {3'd0, beat.lane[2].rem};
        rs9 = {4'd0, cfg.ring_slots};
        lw  = '0;
        lh  = '0;
        k   = '0;
        k9  = '0;
        bot = '0;
        rgt = '0;
        res_next       = '0;
        res_next.hit   = beat.hit;
        res_next.total = beat.total;

        case (cfg.grid_mode)
            mtl_pkg::MODE_GRID:
            begin
                res_next.col = mtl_pkg::mul8(r2, sw);
                res_next.row = mtl_pkg::mul8(q2, sh);
                res_next.w   = sw;
                res_next.h   = sh;
            end
            mtl_pkg::MODE_HEADERS:
            begin
                if (idx < 8'd2)
                begin
                    res_next.col = idx[0] ? (ac >> 1) : 8'd0;
                    res_next.w   = ac >> 1;
                    res_next.h   = dc >> 1;
                end
                else
                begin
                    res_next.col = mtl_pkg::mul8(r2, sw);
                    res_next.row = (dc >> 1) + mtl_pkg::mul8(q2, dc >> 2);
                    res_next.w   = sw;
                    res_next.h   = dc >> 2;
                end
            end
            mtl_pkg::MODE_CORNERS:
            begin
                if (idx < 8'd3)
                begin
                    res_next.col = idx[0] ? (ac >> 1) : 8'd0;
                    res_next.row = idx[1] ? (dc >> 1) : 8'd0;
                    res_next.w   = ac >> 1;
                    res_next.h   = dc >> 1;
                end
                else
                begin
                    k = idx - 8'd3;
                    res_next.col = (ac >> 1) + (k[0] ? (ac >> 2) : 8'd0);
                    res_next.row = (dc >> 1) + (k[1] ? (dc >> 2) : 8'd0);
                    res_next.w   = ac >> 2;
                    res_next.h   = dc >> 2;
                end
            end
            mtl_pkg::MODE_TOP_LEFT:
            begin
                lw = ac - sw;
                lh = dc - sh;
                if (idx == 8'd0)
                begin
                    res_next.w = lw;
                    res_next.h = lh;
                end
                else if ({1'b0, idx} <= rs9)
                begin
                    res_next.col = mtl_pkg::mul8(idx - 8'd1, sw);
                    res_next.row = lh;
                    res_next.w   = sw;
                    res_next.h   = sh;
                end
                else
                begin
                    res_next.col = lw;
                    res_next.row = mtl_pkg::mul8(idx - 8'd1 - rs9[7:0], sh);
                    res_next.w   = sw;
                    res_next.h   = sh;
                end
            end
            mtl_pkg::MODE_CENTER, mtl_pkg::MODE_QUAD_CENTER:
            begin
                if (cfg.grid_mode == mtl_pkg::MODE_CENTER)
                begin
                    lw  = ac - (sw << 1);
                    lh  = dc - (sh << 1);
                    bot = sh + lh;
                    rgt = sw + lw;
                    k   = idx - 8'd1;
                end
                else
                begin
                    lw  = (ac - (sw << 1)) >> 1;
                    lh  = (dc - (sh << 1)) >> 1;
                    bot = sh + (lh << 1);
                    rgt = sw + (lw << 1);
                    k   = idx - 8'd4;
                end
                k9 = {1'b0, k};
                if (cfg.grid_mode == mtl_pkg::MODE_CENTER && idx == 8'd0)
                begin
                    res_next.col = sw;
                    res_next.row = sh;
                    res_next.w   = lw;
                    res_next.h   = lh;
                end
                else if (cfg.grid_mode == mtl_pkg::MODE_QUAD_CENTER && idx < 8'd4)
                begin
                    res_next.col = sw + (idx[0] ? lw : 8'd0);
                    res_next.row = sh + (idx[1] ? lh : 8'd0);
                    res_next.w   = lw;
                    res_next.h   = lh;
                end
                else
                begin
                    // Ring of small tiles: top, bottom, left, right
                    res_next.w = sw;
                    res_next.h = sh;
                    if (k9 < rs9)
                        res_next.col = mtl_pkg::mul8(k, sw);
                    else if (k9 < (rs9 << 1))
                    begin
                        res_next.col = mtl_pkg::mul8(k - rs9[7:0], sw);
                        res_next.row = bot;
                    end
                    else if (k9 < (rs9 << 1) + rs9 - 9'd2)
                        res_next.row = sh + mtl_pkg::mul8(k - (rs9[7:0] << 1), sh);
                    else
                    begin
                        res_next.col = rgt;
                        res_next.row = sh + mtl_pkg::mul8(
                            k - ((rs9[7:0] << 1) + rs9[7:0] - 8'd2), sh);
                    end
                end
            end
            default:
            begin
                res_next.col = '0;
            end
        endcase

        // Drop the rectangle of a tile that does not exist
        if (!beat.hit)
        begin
            res_next.col = '0;
            res_next.row = '0;
            res_next.w   = '0;
            res_next.h   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

endmodule
